### rtl/calendar_date_arithmetic_assert.svh
// ----------------------------------------------------------------------------
// Calendar date arithmetic assertion macros
// Shorthand for clocked checks on the block's ports, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_ARITHMETIC_ASSERT_SVH
`define CALENDAR_DATE_ARITHMETIC_ASSERT_SVH

// check a condition in the same cycle as its trigger
`define CDA_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

// check a condition in the cycle after its trigger
`define CDA_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

### rtl/cda_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date arithmetic package
// Pipeline depths, operation codes, shared types and the month offset table.
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

  localparam int JDN_STAGES   = 3;
  localparam int SHIFT_STAGES = 7;
  localparam int PIPE_STAGES  = JDN_STAGES + SHIFT_STAGES;

  localparam int YEAR_BIAS  = 4800;
  localparam int JDN_OFFSET = 32045;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_SUB  = 2'd1,
    MODE_DIFF = 2'd2,
    MODE_NOP  = 2'd3
  } cda_mode_t;

  typedef struct packed {
    logic [22:0] jdn;
    logic        valid;
    logic        leap;
  } cda_date_info_t;

  // days before the shifted month, March based: (153 * mm + 2) / 5
  function automatic logic [8:0] month_offset(input logic [3:0] mm);
    logic [8:0] ofs;
    case (mm)
      4'd0:    ofs = 9'd0;
      4'd1:    ofs = 9'd31;
      4'd2:    ofs = 9'd61;
      4'd3:    ofs = 9'd92;
      4'd4:    ofs = 9'd122;
      4'd5:    ofs = 9'd153;
      4'd6:    ofs = 9'd184;
      4'd7:    ofs = 9'd214;
      4'd8:    ofs = 9'd245;
      4'd9:    ofs = 9'd275;
      4'd10:   ofs = 9'd306;
      4'd11:   ofs = 9'd337;
      4'd12:   ofs = 9'd367;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

`default_nettype wire

### rtl/cda_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// Calendar date arithmetic pipeline control
// Valid bits per stage and per-stage load enables; bubbles collapse on stall.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_pipe_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cda_pkg::PIPE_STAGES-1:0] en
);
  import cda_pkg::*;

  logic [PIPE_STAGES-1:0] vld;

  always_comb begin
    en[PIPE_STAGES-1] = !vld[PIPE_STAGES-1] || !out_stall;
    for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[PIPE_STAGES-1];

endmodule

`default_nettype wire

### rtl/cda_jdn.sv
// ----------------------------------------------------------------------------
// Calendar date arithmetic date to day number
// Three-stage Julian day number of a date, with validity and leap flags.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_jdn (
  input  logic                          clk,
  input  logic [cda_pkg::JDN_STAGES-1:0] en,
  input  logic [4:0]                    day,
  input  logic [3:0]                    month,
  input  logic [13:0]                   year,
  output cda_pkg::cda_date_info_t       info
);
  import cda_pkg::*;

  localparam logic [14:0] RECIP_100 = 15'd20972;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  logic        early_c;
  logic [14:0] yy_c;
  logic [3:0]  mm_c;
  logic [28:0] yprod_c;

  logic [14:0] s1_yy;
  logic [8:0]  s1_moff;
  logic [4:0]  s1_day;
  logic [3:0]  s1_month;
  logic [13:0] s1_year;
  logic [7:0]  s1_yq;

  logic [29:0] yyprod_c;
  logic [23:0] yy365_c;
  logic [13:0] rem_c;
  logic        leap_c;
  logic        valid_c;

  logic [23:0] s2_yy365;
  logic [12:0] s2_yy4;
  logic [8:0]  s2_yyq;
  logic [4:0]  s2_day;
  logic [8:0]  s2_moff;
  logic        s2_leap;
  logic        s2_valid;

  logic [23:0] sum_c;

  always_comb begin
    early_c = month <= 4'd2;
    yy_c    = 15'(year) + 15'(YEAR_BIAS) - {14'd0, early_c};
    mm_c    = early_c ? month + 4'd9 : month - 4'd3;
    yprod_c = 29'(year) * 29'(RECIP_100);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_yy    <= yy_c;
      s1_moff  <= month_offset(mm_c);
      s1_day   <= day;
      s1_month <= month;
      s1_year  <= year;
      s1_yq    <= yprod_c[28:21];
    end
  end

  always_comb begin
    yyprod_c = 30'(s1_yy) * 30'(RECIP_100);
    yy365_c  = 24'(s1_yy) * 24'd365;
    rem_c    = s1_year - 14'(14'(s1_yq) * 14'd100);
    leap_c   = (s1_year[1:0] == 2'b00) && ((rem_c != 14'd0) || (s1_yq[1:0] == 2'b00));
    valid_c  = (s1_year != 14'd0) && (s1_month >= 4'd1) && (s1_month <= 4'd12) &&
               (s1_day != 5'd0) && (s1_day <= month_days(s1_month, leap_c));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_yy365 <= yy365_c;
      s2_yy4   <= s1_yy[14:2];
      s2_yyq   <= yyprod_c[29:21];
      s2_day   <= s1_day;
      s2_moff  <= s1_moff;
      s2_leap  <= leap_c;
      s2_valid <= valid_c;
    end
  end

  always_comb begin
    sum_c = s2_yy365 + 24'(s2_yy4) + 24'(s2_day) + 24'(s2_moff) + 24'(s2_yyq[8:2])
            - 24'(s2_yyq) - 24'(JDN_OFFSET);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      info.jdn   <= sum_c[22:0];
      info.valid <= s2_valid;
      info.leap  <= s2_leap;
    end
  end

endmodule

`default_nettype wire

### rtl/cda_shift.sv
// ----------------------------------------------------------------------------
// Calendar date arithmetic shift and back conversion
// Seven-stage day shift, range clamp and day number to date conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_shift #(
  parameter int MAX_YEAR = 9999
) (
  input  logic                            clk,
  input  logic [cda_pkg::SHIFT_STAGES-1:0] en,
  input  cda_pkg::cda_date_info_t         main_info,
  input  cda_pkg::cda_date_info_t         other_info,
  input  cda_pkg::cda_mode_t              mode,
  input  logic signed [22:0]              amount,
  output logic [4:0]                      day_out,
  output logic [3:0]                      month_out,
  output logic [13:0]                     year_out,
  output logic [22:0]                     day_difference,
  output logic [22:0]                     julian_day,
  output logic                            input_valid,
  output logic                            other_valid,
  output logic                            leap_year,
  output logic                            out_of_range
);
  import cda_pkg::*;

  function automatic int jdn_of(input int d, input int m, input int y);
    int a;
    int yy;
    int mm;
    a  = (m <= 2) ? 1 : 0;
    yy = y + YEAR_BIAS - a;
    mm = m + 12 * a - 3;
    return d + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400 - JDN_OFFSET;
  endfunction

  localparam int                 JDN_BIAS     = 32044;
  localparam logic signed [27:0] JD_LO        = 28'(jdn_of(1, 1, 1));
  localparam logic signed [27:0] JD_HI        = 28'(jdn_of(31, 12, MAX_YEAR));
  localparam logic [13:0]        YEAR_CAP     = 14'(MAX_YEAR);
  localparam logic [25:0]        RECIP_146097 = 26'd60207212;
  localparam logic [17:0]        RECIP_1461   = 18'd183735;
  localparam logic [12:0]        RECIP_153    = 13'd6854;
  localparam int                 SIDE_REGS    = SHIFT_STAGES - 1;

  typedef struct packed {
    cda_mode_t   mode;
    logic        below;
    logic        above;
    logic [22:0] diff;
    logic [22:0] jdn;
    logic        in_ok;
    logic        other_ok;
    logic        leap;
  } side_t;

  side_t side [SIDE_REGS];
  side_t side_c;

  logic signed [24:0] jd_c;
  logic signed [24:0] amt_c;
  logic signed [24:0] t_c;
  logic signed [27:0] t_w;
  logic [23:0]        a_c;
  logic [23:0]        s4_a;

  logic [51:0] bprod_c;
  logic [23:0] s5_a;
  logic [8:0]  s5_b;

  logic [26:0] cent_c;
  logic [23:0] c_c;
  logic [8:0]  s6_b;
  logic [15:0] s6_c;

  logic [35:0] dprod_c;
  logic [8:0]  s7_b;
  logic [15:0] s7_c;
  logic [6:0]  s7_dd;

  logic [17:0] quad_c;
  logic [15:0] e_c;
  logic [8:0]  s8_b;
  logic [6:0]  s8_dd;
  logic [8:0]  s8_e;

  logic [10:0] xm_c;
  logic [23:0] mprod_c;
  logic [8:0]  s9_b;
  logic [6:0]  s9_dd;
  logic [8:0]  s9_e;
  logic [3:0]  s9_mm;

  logic        late_c;
  logic [8:0]  day_c;
  logic [3:0]  month_c;
  logic [16:0] year_c;
  logic [4:0]  day_out_next;
  logic [3:0]  month_out_next;
  logic [13:0] year_out_next;
  logic [22:0] diff_next;
  logic        oor_next;

  // shift and range check
  always_comb begin
    jd_c  = signed'({2'b00, main_info.jdn});
    amt_c = signed'({{2{amount[22]}}, amount});
    t_c   = (mode == MODE_SUB) ? jd_c - amt_c : jd_c + amt_c;
    t_w   = signed'({{3{t_c[24]}}, t_c});
    a_c   = t_c[23:0] + 24'(JDN_BIAS);
    side_c.mode     = mode;
    side_c.below    = t_w < JD_LO;
    side_c.above    = t_w > JD_HI;
    side_c.diff     = main_info.jdn - other_info.jdn;
    side_c.jdn      = main_info.jdn;
    side_c.in_ok    = main_info.valid;
    side_c.other_ok = other_info.valid;
    side_c.leap     = main_info.leap;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side[0] <= side_c;
      s4_a    <= a_c;
    end
    for (int k = 1; k < SIDE_REGS; k++) begin
      if (en[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  // 400-year cycles
  always_comb begin
    bprod_c = 52'({s4_a, 2'b11}) * 52'(RECIP_146097);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s5_a <= s4_a;
      s5_b <= bprod_c[51:43];
    end
  end

  always_comb begin
    cent_c = 27'(s5_b) * 27'd146097;
    c_c    = s5_a - cent_c[25:2];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s6_b <= s5_b;
      s6_c <= c_c[15:0];
    end
  end

  // 4-year cycles
  always_comb begin
    dprod_c = 36'({s6_c, 2'b11}) * 36'(RECIP_1461);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s7_b  <= s6_b;
      s7_c  <= s6_c;
      s7_dd <= dprod_c[34:28];
    end
  end

  always_comb begin
    quad_c = 18'(s7_dd) * 18'd1461;
    e_c    = s7_c - quad_c[17:2];
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s8_b  <= s7_b;
      s8_dd <= s7_dd;
      s8_e  <= e_c[8:0];
    end
  end

  // month within the March based year
  always_comb begin
    xm_c    = 11'(s8_e) * 11'd5 + 11'd2;
    mprod_c = 24'(xm_c) * 24'(RECIP_153);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s9_b  <= s8_b;
      s9_dd <= s8_dd;
      s9_e  <= s8_e;
      s9_mm <= mprod_c[23:20];
    end
  end

  // assemble date, clamp and select by operation
  always_comb begin
    late_c  = s9_mm >= 4'd10;
    day_c   = s9_e - month_offset(s9_mm) + 9'd1;
    month_c = late_c ? s9_mm - 4'd9 : s9_mm + 4'd3;
    year_c  = 17'(s9_b) * 17'd100 + 17'(s9_dd) + {16'd0, late_c} - 17'(YEAR_BIAS);
    day_out_next   = 5'd0;
    month_out_next = 4'd0;
    year_out_next  = 14'd0;
    diff_next      = 23'd0;
    oor_next       = 1'b0;
    case (side[SIDE_REGS-1].mode) inside
      MODE_ADD, MODE_SUB: begin
        if (side[SIDE_REGS-1].below) begin
          day_out_next   = 5'd1;
          month_out_next = 4'd1;
          year_out_next  = 14'd1;
          oor_next       = 1'b1;
        end else if (side[SIDE_REGS-1].above) begin
          day_out_next   = 5'd31;
          month_out_next = 4'd12;
          year_out_next  = YEAR_CAP;
          oor_next       = 1'b1;
        end else begin
          day_out_next   = day_c[4:0];
          month_out_next = month_c;
          year_out_next  = year_c[13:0];
        end
      end
      MODE_DIFF: begin
        diff_next = side[SIDE_REGS-1].diff;
      end
      MODE_NOP: begin
        diff_next = 23'd0;
      end
      default: begin
        diff_next = 23'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[SHIFT_STAGES-1]) begin
      day_out        <= day_out_next;
      month_out      <= month_out_next;
      year_out       <= year_out_next;
      day_difference <= diff_next;
      out_of_range   <= oor_next;
      julian_day     <= side[SIDE_REGS-1].jdn;
      input_valid    <= side[SIDE_REGS-1].in_ok;
      other_valid    <= side[SIDE_REGS-1].other_ok;
      leap_year      <= side[SIDE_REGS-1].leap;
    end
  end

endmodule

`default_nettype wire

### rtl/calendar_date_arithmetic.sv
// ----------------------------------------------------------------------------
// Calendar date arithmetic
// Gregorian date shift and date difference through the Julian day number.
// ----------------------------------------------------------------------------
// Takes one request per clock while out_stall stays low and returns each
// result from the last of the ten register stages of the pipeline (three for
// the day number of each date, seven for the shift, the reciprocal divisions
// of the back conversion and the output register).
// A stalled output holds the pipeline only as far as it is full: empty stages
// still take new requests. Modes: add amount, subtract amount, difference of
// the two dates, and no operation. Shifted dates outside years 1 to MAX_YEAR
// clamp to the nearest end and raise out_of_range.
`default_nettype none

module calendar_date_arithmetic #(
  parameter int MAX_YEAR = 9999
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic [4:0]         day_in,
  input  logic [3:0]         month_in,
  input  logic [13:0]        year_in,
  input  logic signed [22:0] amount,
  input  logic [4:0]         other_day,
  input  logic [3:0]         other_month,
  input  logic [13:0]        other_year,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         day_out,
  output logic [3:0]         month_out,
  output logic [13:0]        year_out,
  output logic signed [22:0] day_difference,
  output logic [22:0]        julian_day,
  output logic               input_valid,
  output logic               other_valid,
  output logic               leap_year,
  output logic               out_of_range
);
  import cda_pkg::*;

  logic [PIPE_STAGES-1:0] en;
  cda_date_info_t         main_info;
  cda_date_info_t         other_info;
  cda_mode_t              mode_d   [JDN_STAGES];
  logic signed [22:0]     amount_d [JDN_STAGES];
  logic [22:0]            diff;

  cda_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .en        (en)
  );

  cda_jdn u_jdn_main (
    .clk   (clk),
    .en    (en[JDN_STAGES-1:0]),
    .day   (day_in),
    .month (month_in),
    .year  (year_in),
    .info  (main_info)
  );

  cda_jdn u_jdn_other (
    .clk   (clk),
    .en    (en[JDN_STAGES-1:0]),
    .day   (other_day),
    .month (other_month),
    .year  (other_year),
    .info  (other_info)
  );

  // carry operation and amount alongside the day number stages
  always_ff @(posedge clk) begin
    if (en[0]) begin
      mode_d[0]   <= cda_mode_t'(mode);
      amount_d[0] <= amount;
    end
    for (int k = 1; k < JDN_STAGES; k++) begin
      if (en[k]) begin
        mode_d[k]   <= mode_d[k-1];
        amount_d[k] <= amount_d[k-1];
      end
    end
  end

  cda_shift #(
    .MAX_YEAR (MAX_YEAR)
  ) u_shift (
    .clk            (clk),
    .en             (en[PIPE_STAGES-1:JDN_STAGES]),
    .main_info      (main_info),
    .other_info     (other_info),
    .mode           (mode_d[JDN_STAGES-1]),
    .amount         (amount_d[JDN_STAGES-1]),
    .day_out        (day_out),
    .month_out      (month_out),
    .year_out       (year_out),
    .day_difference (diff),
    .julian_day     (julian_day),
    .input_valid    (input_valid),
    .other_valid    (other_valid),
    .leap_year      (leap_year),
    .out_of_range   (out_of_range)
  );

  assign day_difference = signed'(diff);

endmodule

`default_nettype wire

### rtl/cda_checker.sv
// ----------------------------------------------------------------------------
// Calendar date arithmetic checker
// Port-level checks on result delivery and result field consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "calendar_date_arithmetic_assert.svh"

module cda_checker #(
  parameter int MAX_YEAR = 9999
) (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [4:0]         day_out,
  input logic [3:0]         month_out,
  input logic [13:0]        year_out,
  input logic signed [22:0] day_difference,
  input logic [22:0]        julian_day,
  input logic               out_of_range
);

  localparam logic [13:0] YEAR_CAP = 14'(MAX_YEAR);

  `CDA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  `CDA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(day_out) && $stable(month_out) && $stable(year_out) && $stable(day_difference) && $stable(julian_day), "result changed while stalled")

  `CDA_ASSERT_NOW(a_clamp, out_valid && out_of_range, (day_out == 5'd1 && month_out == 4'd1 && year_out == 14'd1) || (day_out == 5'd31 && month_out == 4'd12 && year_out == YEAR_CAP), "out of range date not clamped")

  `CDA_ASSERT_NOW(a_diff_only, out_valid && day_difference != 23'sd0, day_out == 5'd0 && month_out == 4'd0 && year_out == 14'd0 && !out_of_range, "difference mixed with shifted date")

  `CDA_ASSERT_NOW(a_date_shape, out_valid && month_out != 4'd0, month_out <= 4'd12 && day_out != 5'd0 && day_difference == 23'sd0, "malformed shifted date")

endmodule

bind calendar_date_arithmetic cda_checker #(
  .MAX_YEAR (MAX_YEAR)
) u_cda_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .day_out        (day_out),
  .month_out      (month_out),
  .year_out       (year_out),
  .day_difference (day_difference),
  .julian_day     (julian_day),
  .out_of_range   (out_of_range)
);

`default_nettype wire

### verif/calendar_date_arithmetic_tb.sv
// ----------------------------------------------------------------------------
// Calendar date arithmetic testbench
// Drives add, subtract, difference and no-op requests through the block and
// checks every result field against a day-number model of the Gregorian
// calendar kept here. Directed edge dates come first, then random requests
// under three patterns of idling on the request and result sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module calendar_date_arithmetic_tb;
  import cda_pkg::*;

  localparam int  MAX_YEAR      = 9999;
  localparam int  PHASE_COUNT   = 600;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    cda_mode_t          mode;
    logic [4:0]         day;
    logic [3:0]         month;
    logic [13:0]        year;
    logic signed [22:0] amount;
    logic [4:0]         o_day;
    logic [3:0]         o_month;
    logic [13:0]        o_year;
  } date_request_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [22:0] diff;
    logic [22:0] jdn;
    logic        in_ok;
    logic        other_ok;
    logic        leap;
    logic        oor;
  } date_result_t;

  class date_result_board;
    date_result_t pending_results[$];
    int error_count;
    int mode_count[4];
    int clamp_count;
    int bad_date_count;
    int checked_count;

    function bit is_leap(longint y);
      return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    function bit is_real_date(longint d, longint m, longint y);
      longint lim;
      if (y < 1 || m < 1 || m > 12 || d < 1) return 1'b0;
      case (m)
        4, 6, 9, 11: lim = 30;
        2:           lim = is_leap(y) ? 29 : 28;
        default:     lim = 31;
      endcase
      return d <= lim;
    endfunction

    function longint day_number(longint d, longint m, longint y);
      longint a, yy, mm;
      a  = (m <= 2) ? 1 : 0;
      yy = y + 4800 - a;
      mm = m + 12 * a - 3;
      return d + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400 - 32045;
    endfunction

    function date_result_t predict_date_result(date_request_t r);
      date_result_t res;
      longint jd, lo, hi, t, a, b, c, dd, e, mm;
      res    = '0;
      jd     = day_number(r.day, r.month, r.year);
      lo     = day_number(1, 1, 1);
      hi     = day_number(31, 12, MAX_YEAR);
      if (r.mode == MODE_ADD || r.mode == MODE_SUB) begin
        t = (r.mode == MODE_ADD) ? jd + longint'(r.amount) : jd - longint'(r.amount);
        if (t < lo) begin
          res.oor = 1'b1; res.day = 5'd1; res.month = 4'd1; res.year = 14'd1;
        end else if (t > hi) begin
          res.oor = 1'b1; res.day = 5'd31; res.month = 4'd12; res.year = MAX_YEAR[13:0];
        end else begin
          a  = t + 32044;
          b  = (4 * a + 3) / 146097;
          c  = a - (146097 * b) / 4;
          dd = (4 * c + 3) / 1461;
          e  = c - (1461 * dd) / 4;
          mm = (5 * e + 2) / 153;
          res.day   = 5'(e - (153 * mm + 2) / 5 + 1);
          res.month = 4'(mm + 3 - 12 * (mm / 10));
          res.year  = 14'(100 * b + dd - 4800 + mm / 10);
        end
      end else if (r.mode == MODE_DIFF) begin
        res.diff = 23'(jd - day_number(r.o_day, r.o_month, r.o_year));
      end
      res.jdn      = 23'(jd);
      res.in_ok    = is_real_date(r.day, r.month, r.year);
      res.other_ok = is_real_date(r.o_day, r.o_month, r.o_year);
      res.leap     = is_leap(r.year);
      return res;
    endfunction

    function void note_request(date_request_t r);
      date_result_t res;
      res = predict_date_result(r);
      mode_count[r.mode]++;
      if (res.oor) clamp_count++;
      if (!res.in_ok) bad_date_count++;
      pending_results.push_back(res);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        error_count++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(date_result_t got);
      date_result_t want;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      checked_count++;
      compare_field("day_out", want.day, got.day);
      compare_field("month_out", want.month, got.month);
      compare_field("year_out", want.year, got.year);
      compare_field("day_difference", want.diff, got.diff);
      compare_field("julian_day", want.jdn, got.jdn);
      compare_field("input_valid", want.in_ok, got.in_ok);
      compare_field("other_valid", want.other_ok, got.other_ok);
      compare_field("leap_year", want.leap, got.leap);
      compare_field("out_of_range", want.oor, got.oor);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         mode = '0;
  logic [4:0]         day_in = '0;
  logic [3:0]         month_in = '0;
  logic [13:0]        year_in = '0;
  logic signed [22:0] amount = '0;
  logic [4:0]         other_day = '0;
  logic [3:0]         other_month = '0;
  logic [13:0]        other_year = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [4:0]         day_out;
  logic [3:0]         month_out;
  logic [13:0]        year_out;
  logic signed [22:0] day_difference;
  logic [22:0]        julian_day;
  logic               input_valid;
  logic               other_valid;
  logic               leap_year;
  logic               out_of_range;

  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  longint cycle_count   = 0;
  date_result_board board;

  calendar_date_arithmetic #(
    .MAX_YEAR(MAX_YEAR)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .day_in(day_in),
    .month_in(month_in),
    .year_in(year_in),
    .amount(amount),
    .other_day(other_day),
    .other_month(other_month),
    .other_year(other_year),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .day_out(day_out),
    .month_out(month_out),
    .year_out(year_out),
    .day_difference(day_difference),
    .julian_day(julian_day),
    .input_valid(input_valid),
    .other_valid(other_valid),
    .leap_year(leap_year),
    .out_of_range(out_of_range)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("calendar_date_arithmetic regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_result({day_out, month_out, year_out, day_difference, julian_day,
                          input_valid, other_valid, leap_year, out_of_range});
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic date_request_t make_request(cda_mode_t m, int d, int mo, int y,
                                                 int amt, int od, int om, int oy);
    date_request_t r;
    r.mode    = m;
    r.day     = 5'(d);
    r.month   = 4'(mo);
    r.year    = 14'(y);
    r.amount  = 23'(amt);
    r.o_day   = 5'(od);
    r.o_month = 4'(om);
    r.o_year  = 14'(oy);
    return r;
  endfunction

  function automatic date_request_t random_request();
    date_request_t r;
    int pick;
    pick   = $urandom_range(99);
    r.mode = (pick < 35) ? MODE_ADD : (pick < 65) ? MODE_SUB :
             (pick < 93) ? MODE_DIFF : MODE_NOP;
    if ($urandom_range(99) < 80) begin
      r.day     = ($urandom_range(99) < 75) ? 5'($urandom_range(1, 28)) : 5'($urandom_range(29, 31));
      r.month   = 4'($urandom_range(1, 12));
      r.year    = 14'($urandom_range(1, MAX_YEAR));
      r.o_day   = 5'($urandom_range(1, 28));
      r.o_month = 4'($urandom_range(1, 12));
      r.o_year  = 14'($urandom_range(1, MAX_YEAR));
    end else begin
      r.day     = 5'($urandom_range(31));
      r.month   = 4'($urandom_range(15));
      r.year    = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(MAX_YEAR));
      r.o_day   = 5'($urandom_range(31));
      r.o_month = 4'($urandom_range(15));
      r.o_year  = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(MAX_YEAR));
    end
    pick = $urandom_range(99);
    if (pick < 40)
      r.amount = 23'($urandom_range(2000) - 1000);
    else if (pick < 70)
      r.amount = 23'($urandom_range(6000000) - 3000000);
    else
      r.amount = 23'($urandom);
    return r;
  endfunction

  task automatic push_request(input date_request_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= r.mode;
    day_in      <= r.day;
    month_in    <= r.month;
    year_in     <= r.year;
    amount      <= r.amount;
    other_day   <= r.o_day;
    other_month <= r.o_month;
    other_year  <= r.o_year;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(r);
  endtask

  // hold off new requests until every outstanding result has returned
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    date_request_t edge_cases[$];
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    edge_cases.push_back(make_request(MODE_ADD, 1, 1, 1, 0, 1, 1, 1));
    edge_cases.push_back(make_request(MODE_ADD, 28, 2, 2000, 1, 1, 1, 1));
    edge_cases.push_back(make_request(MODE_ADD, 28, 2, 1900, 1, 1, 1, 1));
    edge_cases.push_back(make_request(MODE_ADD, 29, 2, 2400, 1, 1, 1, 1));
    edge_cases.push_back(make_request(MODE_ADD, 31, 12, 1999, 1, 1, 1, 1));
    edge_cases.push_back(make_request(MODE_SUB, 1, 3, 2024, 1, 1, 1, 1));
    edge_cases.push_back(make_request(MODE_ADD, 31, 12, MAX_YEAR, 1, 1, 1, 1));
    edge_cases.push_back(make_request(MODE_ADD, 31, 12, MAX_YEAR, 0, 1, 1, 1));
    edge_cases.push_back(make_request(MODE_SUB, 1, 1, 1, 1, 1, 1, 1));
    edge_cases.push_back(make_request(MODE_ADD, 1, 1, 1, 4194303, 1, 1, 1));
    edge_cases.push_back(make_request(MODE_ADD, 31, 12, MAX_YEAR, -4194304, 1, 1, 1));
    edge_cases.push_back(make_request(MODE_SUB, 1, 1, 1, -4194304, 1, 1, 1));
    edge_cases.push_back(make_request(MODE_SUB, 31, 12, MAX_YEAR, 4194303, 1, 1, 1));
    edge_cases.push_back(make_request(MODE_DIFF, 31, 12, MAX_YEAR, 0, 1, 1, 1));
    edge_cases.push_back(make_request(MODE_DIFF, 1, 1, 1, 0, 31, 12, MAX_YEAR));
    edge_cases.push_back(make_request(MODE_DIFF, 15, 6, 2020, 0, 0, 13, 0));
    edge_cases.push_back(make_request(MODE_DIFF, 31, 15, 16383, 0, 31, 15, 16383));
    edge_cases.push_back(make_request(MODE_ADD, 0, 0, 0, 0, 0, 0, 0));
    edge_cases.push_back(make_request(MODE_ADD, 31, 15, 16383, -4194304, 0, 0, 0));
    edge_cases.push_back(make_request(MODE_SUB, 29, 2, 0, 1000000, 29, 2, 0));
    edge_cases.push_back(make_request(MODE_ADD, 29, 2, 2001, 1, 31, 4, 2023));
    edge_cases.push_back(make_request(MODE_DIFF, 30, 4, 2023, 0, 31, 4, 2023));
    edge_cases.push_back(make_request(MODE_NOP, 29, 2, 2000, 12345, 1, 1, 1));
    edge_cases.push_back(make_request(MODE_NOP, 0, 0, 0, -1, 31, 15, 16383));
    foreach (edge_cases[i]) push_request(edge_cases[i]);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 88 : 0;
      recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 37 : 0;
      for (int n = 0; n < PHASE_COUNT; n++) begin
        push_request(random_request());
        if (n == PHASE_COUNT / 2) drain_results();
      end
    end

    drain_results();
    recv_idle_pct = 0;
    repeat (3 * PIPE_STAGES) @(posedge clk);

    $display("checked %0d results: %0d add, %0d subtract, %0d difference, %0d no-op",
             board.checked_count, board.mode_count[MODE_ADD], board.mode_count[MODE_SUB],
             board.mode_count[MODE_DIFF], board.mode_count[MODE_NOP]);
    $display("clamped shifts %0d, invalid main dates %0d, mismatches %0d",
             board.clamp_count, board.bad_date_count, board.error_count);
    if (board.error_count == 0 && board.pending() == 0) begin
      $display("calendar_date_arithmetic regression: pass");
    end else begin
      $display("calendar_date_arithmetic regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
